FILE: rtl/kbct_pkg.sv
// ----------------------------------------------------------------------------
// kbct_pkg
// Types, constants and the keypad ladder classifier for the countdown timer.
// ----------------------------------------------------------------------------
package kbct_pkg;

    localparam int unsigned LEVEL_W  = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CURSOR_W = 3;
    localparam int unsigned MIN_W    = 7;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned NUM_LIMITS = 5;

    localparam logic [MIN_W-1:0] MIN_MAX = 7'd99;
    localparam logic [SEC_W-1:0] SEC_MAX = 6'd59;

    typedef enum logic [2:0] {
        KEY_RIGHT  = 3'd0,
        KEY_UP     = 3'd1,
        KEY_DOWN   = 3'd2,
        KEY_LEFT   = 3'd3,
        KEY_SELECT = 3'd4,
        KEY_NONE   = 3'd5
    } t_key;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT_LIMIT  = 3'd0,
        CFG_UP_LIMIT     = 3'd1,
        CFG_DOWN_LIMIT   = 3'd2,
        CFG_LEFT_LIMIT   = 3'd3,
        CFG_SELECT_LIMIT = 3'd4
    } t_cfg_idx;

    // digit positions: tens/units of minutes, tens/units of seconds
    localparam logic [CURSOR_W-1:0] POS_MIN_TENS  = 3'd0;
    localparam logic [CURSOR_W-1:0] POS_MIN_UNITS = 3'd1;
    localparam logic [CURSOR_W-1:0] POS_SEC_TENS  = 3'd3;
    localparam logic [CURSOR_W-1:0] POS_SEC_UNITS = 3'd4;

    localparam logic [LEVEL_W-1:0] LIMIT_RESET [NUM_LIMITS] =
        '{10'd72, 10'd237, 10'd419, 10'd625, 10'd883};

    typedef logic [LEVEL_W-1:0] t_limits [NUM_LIMITS];

    // first class whose limit the sample is below wins
    function automatic t_key classify(input logic [LEVEL_W-1:0] level,
                                      input t_limits lim);
        t_key key;
        key = KEY_NONE;
        priority if (level < lim[0]) key = KEY_RIGHT;
        else if (level < lim[1]) key = KEY_UP;
        else if (level < lim[2]) key = KEY_DOWN;
        else if (level < lim[3]) key = KEY_LEFT;
        else if (level < lim[4]) key = KEY_SELECT;
        else key = KEY_NONE;
        return key;
    endfunction

endpackage

FILE: rtl/keypad_set_countdown_timer.sv
// ----------------------------------------------------------------------------
// keypad_set_countdown_timer
// MM:SS countdown timer set from a resistor-ladder keypad.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request per item:
//   i_op = 0 is a keypad ADC sample in i_key_level, i_op = 1 a one-second
//   tick. Every request yields exactly one result on the output channel
//   (o_out_valid / i_out_stall): mode, cursor, shown time, finished flag
//   and the classified key.
//   The request is registered, then decoded and the timer state updated
//   into the result register. One request is taken every cycle while the
//   receiver does not stall; the rate is set by the input and result
//   registers only. When the receiver stalls, the result register holds
//   and the stall reaches o_in_stall once the input register is also full.
//   Ladder thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while the block is idle; indexes past the select limit are ignored.
//   Reset (synchronous, active low) restores the default thresholds, edit
//   mode, cursor 0, set time 00:00 and an armed key lock.
// ----------------------------------------------------------------------------
module keypad_set_countdown_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [kbct_pkg::LEVEL_W-1:0]  i_key_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_counting,
    output logic [kbct_pkg::CURSOR_W-1:0] o_cursor_pos,
    output logic [kbct_pkg::MIN_W-1:0]    o_minutes_shown,
    output logic [kbct_pkg::SEC_W-1:0]    o_seconds_shown,
    output logic                          o_finished,
    output logic [2:0]                    o_key_code,
    input  logic                          i_cfg_we,
    input  logic [kbct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kbct_pkg::LEVEL_W-1:0]  i_cfg_data
);
    import kbct_pkg::*;

    // configuration
    t_limits r_limit;

    // input register
    logic               r_in_valid;
    logic               r_op;
    logic [LEVEL_W-1:0] r_level;

    // timer state
    logic                r_mode;
    logic                r_armed;
    logic [CURSOR_W-1:0] r_cursor;
    logic [MIN_W-1:0]    r_set_min;
    logic [SEC_W-1:0]    r_set_sec;
    logic [MIN_W-1:0]    r_rem_min;
    logic [SEC_W-1:0]    r_rem_sec;

    logic                n_mode;
    logic                n_armed;
    logic [CURSOR_W-1:0] n_cursor;
    logic [MIN_W-1:0]    n_set_min;
    logic [SEC_W-1:0]    n_set_sec;
    logic [MIN_W-1:0]    n_rem_min;
    logic [SEC_W-1:0]    n_rem_sec;
    logic                n_finished;

    // result register
    logic                r_out_valid;
    logic                r_counting;
    logic [CURSOR_W-1:0] r_cursor_pos;
    logic [MIN_W-1:0]    r_min_shown;
    logic [SEC_W-1:0]    r_sec_shown;
    logic                r_finished;
    t_key                r_key;

    t_key                w_key;
    logic                w_advance;
    logic                w_in_take;
    logic [MIN_W-1:0]    w_min_add;
    logic [MIN_W-1:0]    w_sec_add;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LIMITS; k++) begin
                r_limit[k] <= LIMIT_RESET[k];
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RIGHT_LIMIT:  r_limit[0] <= i_cfg_data;
                CFG_UP_LIMIT:     r_limit[1] <= i_cfg_data;
                CFG_DOWN_LIMIT:   r_limit[2] <= i_cfg_data;
                CFG_LEFT_LIMIT:   r_limit[3] <= i_cfg_data;
                CFG_SELECT_LIMIT: r_limit[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= i_op;
            r_level <= i_key_level;
        end
    end

    assign w_key = (r_op == 1'b0) ? classify(r_level, r_limit) : KEY_NONE;

    // up-step sums, one bit wider than needed for seconds
    always_comb begin
        w_min_add = r_set_min + ((r_cursor == POS_MIN_TENS) ? MIN_W'(10) : MIN_W'(1));
        w_sec_add = MIN_W'(r_set_sec) +
                    ((r_cursor == POS_SEC_TENS) ? MIN_W'(10) : MIN_W'(1));
    end

    always_comb begin
        n_mode     = r_mode;
        n_armed    = r_armed;
        n_cursor   = r_cursor;
        n_set_min  = r_set_min;
        n_set_sec  = r_set_sec;
        n_rem_min  = r_rem_min;
        n_rem_sec  = r_rem_sec;
        n_finished = 1'b0;

        if (r_op == 1'b0) begin
            if (!r_mode) begin
                if (w_key == KEY_SELECT) begin
                    n_rem_min = r_set_min;
                    n_rem_sec = r_set_sec;
                    if (r_set_min == '0 && r_set_sec == '0) begin
                        n_finished = 1'b1;
                    end else begin
                        n_mode = 1'b1;
                    end
                end else if (w_key == KEY_NONE) begin
                    n_armed = 1'b1;
                end else if (r_armed) begin
                    n_armed = 1'b0;
                    unique case (w_key)
                        KEY_RIGHT: begin
                            unique case (r_cursor)
                                POS_MIN_TENS:  n_cursor = POS_MIN_UNITS;
                                POS_MIN_UNITS: n_cursor = POS_SEC_TENS;
                                POS_SEC_TENS:  n_cursor = POS_SEC_UNITS;
                                default:       n_cursor = r_cursor;
                            endcase
                        end
                        KEY_LEFT: begin
                            unique case (r_cursor)
                                POS_SEC_UNITS: n_cursor = POS_SEC_TENS;
                                POS_SEC_TENS:  n_cursor = POS_MIN_UNITS;
                                POS_MIN_UNITS: n_cursor = POS_MIN_TENS;
                                default:       n_cursor = r_cursor;
                            endcase
                        end
                        KEY_UP: begin
                            if (r_cursor == POS_MIN_TENS || r_cursor == POS_MIN_UNITS) begin
                                n_set_min = (w_min_add > MIN_MAX) ? '0 : w_min_add;
                            end else if (r_cursor == POS_SEC_TENS ||
                                         r_cursor == POS_SEC_UNITS) begin
                                n_set_sec = (w_sec_add > MIN_W'(SEC_MAX)) ? '0
                                                                         : w_sec_add[SEC_W-1:0];
                            end
                        end
                        KEY_DOWN: begin
                            // any step below zero wraps to the maximum
                            unique case (r_cursor)
                                POS_MIN_TENS:  n_set_min = (r_set_min < MIN_W'(10)) ? MIN_MAX
                                                         : r_set_min - MIN_W'(10);
                                POS_MIN_UNITS: n_set_min = (r_set_min == '0) ? MIN_MAX
                                                         : r_set_min - MIN_W'(1);
                                POS_SEC_TENS:  n_set_sec = (r_set_sec < SEC_W'(10)) ? SEC_MAX
                                                         : r_set_sec - SEC_W'(10);
                                POS_SEC_UNITS: n_set_sec = (r_set_sec == '0) ? SEC_MAX
                                                         : r_set_sec - SEC_W'(1);
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
        end else if (r_mode) begin
            // tick: borrow from minutes when seconds run out
            if (r_rem_sec != '0) begin
                n_rem_sec = r_rem_sec - SEC_W'(1);
            end else if (r_rem_min != '0) begin
                n_rem_min = r_rem_min - MIN_W'(1);
                n_rem_sec = SEC_MAX;
            end
            if (n_rem_min == '0 && n_rem_sec == '0) begin
                n_mode     = 1'b0;
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_armed   <= 1'b1;
            r_cursor  <= POS_MIN_TENS;
            r_set_min <= '0;
            r_set_sec <= '0;
            r_rem_min <= '0;
            r_rem_sec <= '0;
        end else if (r_in_valid && w_advance) begin
            r_mode    <= n_mode;
            r_armed   <= n_armed;
            r_cursor  <= n_cursor;
            r_set_min <= n_set_min;
            r_set_sec <= n_set_sec;
            r_rem_min <= n_rem_min;
            r_rem_sec <= n_rem_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance) begin
            r_counting   <= n_mode;
            r_cursor_pos <= n_cursor;
            r_min_shown  <= n_mode ? n_rem_min : n_set_min;
            r_sec_shown  <= n_mode ? n_rem_sec : n_set_sec;
            r_finished   <= n_finished;
            r_key        <= w_key;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_counting      = r_counting;
    assign o_cursor_pos    = r_cursor_pos;
    assign o_minutes_shown = r_min_shown;
    assign o_seconds_shown = r_sec_shown;
    assign o_finished      = r_finished;
    assign o_key_code      = r_key;

endmodule

FILE: verif/kbct_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kbct_checker
// Watches both channels and the threshold port of the countdown timer. It
// keeps its own copy of the timer state, works out the display for every
// accepted request and compares each result field against it in order.
// ----------------------------------------------------------------------------
module kbct_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_op,
    input  logic [kbct_pkg::LEVEL_W-1:0]   i_key_level,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_counting,
    input  logic [kbct_pkg::CURSOR_W-1:0]  i_cursor_pos,
    input  logic [kbct_pkg::MIN_W-1:0]     i_minutes_shown,
    input  logic [kbct_pkg::SEC_W-1:0]     i_seconds_shown,
    input  logic                           i_finished,
    input  logic [2:0]                     i_key_code,
    input  logic                           i_cfg_we,
    input  logic [kbct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kbct_pkg::LEVEL_W-1:0]   i_cfg_data,
    output int                             o_mismatches,
    output int                             o_in_flight,
    output logic                           o_counting,
    output logic [kbct_pkg::CURSOR_W-1:0]  o_cursor,
    output logic [kbct_pkg::MIN_W-1:0]     o_set_min,
    output logic [kbct_pkg::SEC_W-1:0]     o_set_sec
);
    import kbct_pkg::*;

    typedef struct packed {
        logic                counting;
        logic [CURSOR_W-1:0] cursor;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic                finished;
        t_key                key;
    } t_timer_view;

    t_timer_view         display_q [$];
    t_timer_view         want;
    int                  mismatch_count;

    logic                timer_mode;
    logic                key_armed;
    logic [CURSOR_W-1:0] edit_cursor;
    logic [MIN_W-1:0]    set_min;
    logic [SEC_W-1:0]    set_sec;
    logic [12:0]         secs_left;
    logic [LEVEL_W-1:0]  thresholds [NUM_LIMITS];

    function automatic t_key decode_key(input logic [LEVEL_W-1:0] level);
        for (int k = 0; k < NUM_LIMITS; k++)
            if (level < thresholds[k])
                return t_key'(k);
        return KEY_NONE;
    endfunction

    // up/down on the digit under the cursor, wrapping past the range
    function automatic void nudge_digit(input logic up);
        case (edit_cursor)
            POS_MIN_TENS: begin
                if (up)
                    set_min = (set_min + 7'd10 > MIN_MAX) ? '0 : set_min + 7'd10;
                else
                    set_min = (set_min < 7'd10) ? MIN_MAX : set_min - 7'd10;
            end
            POS_MIN_UNITS: begin
                if (up)
                    set_min = (set_min == MIN_MAX) ? '0 : set_min + 7'd1;
                else
                    set_min = (set_min == 0) ? MIN_MAX : set_min - 7'd1;
            end
            POS_SEC_TENS: begin
                if (up)
                    set_sec = (7'(set_sec) + 7'd10 > 7'(SEC_MAX)) ? '0 : set_sec + 6'd10;
                else
                    set_sec = (set_sec < 6'd10) ? SEC_MAX : set_sec - 6'd10;
            end
            POS_SEC_UNITS: begin
                if (up)
                    set_sec = (set_sec == SEC_MAX) ? '0 : set_sec + 6'd1;
                else
                    set_sec = (set_sec == 0) ? SEC_MAX : set_sec - 6'd1;
            end
            default: ;
        endcase
    endfunction

    function automatic t_timer_view advance_timer(input logic op,
                                                  input logic [LEVEL_W-1:0] level);
        t_timer_view v;
        t_key        key;
        logic        done;
        key  = KEY_NONE;
        done = 1'b0;
        if (!op) begin
            key = decode_key(level);
            // samples while counting are only classified
            if (!timer_mode) begin
                if (key == KEY_SELECT) begin
                    secs_left = 13'(set_min * 60 + set_sec);
                    if (secs_left == 0)
                        done = 1'b1;
                    else
                        timer_mode = 1'b1;
                end else if (key == KEY_NONE) begin
                    key_armed = 1'b1;
                end else if (key_armed) begin
                    case (key)
                        KEY_RIGHT: begin
                            if (edit_cursor < POS_SEC_UNITS)
                                edit_cursor = (edit_cursor == POS_MIN_UNITS) ?
                                              POS_SEC_TENS : edit_cursor + 3'd1;
                        end
                        KEY_LEFT: begin
                            if (edit_cursor > POS_MIN_TENS)
                                edit_cursor = (edit_cursor == POS_SEC_TENS) ?
                                              POS_MIN_UNITS : edit_cursor - 3'd1;
                        end
                        KEY_UP:   nudge_digit(1'b1);
                        default:  nudge_digit(1'b0);
                    endcase
                    key_armed = 1'b0;
                end
            end
        end else if (timer_mode) begin
            if (secs_left != 0)
                secs_left = secs_left - 13'd1;
            if (secs_left == 0) begin
                timer_mode = 1'b0;
                done       = 1'b1;
            end
        end
        v.counting = timer_mode;
        v.cursor   = edit_cursor;
        if (timer_mode) begin
            v.minutes = MIN_W'(secs_left / 60);
            v.seconds = SEC_W'(secs_left % 60);
        end else begin
            v.minutes = set_min;
            v.seconds = set_sec;
        end
        v.finished = done;
        v.key      = key;
        return v;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d",
                     $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            display_q.delete();
            mismatch_count = 0;
            timer_mode     = 1'b0;
            key_armed      = 1'b1;
            edit_cursor    = POS_MIN_TENS;
            set_min        = '0;
            set_sec        = '0;
            secs_left      = '0;
            for (int k = 0; k < NUM_LIMITS; k++)
                thresholds[k] = LIMIT_RESET[k];
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (display_q.size() == 0) begin
                    $display("%0t: result with no request outstanding", $time);
                    mismatch_count++;
                end else begin
                    want = display_q.pop_front();
                    check_field("counting", want.counting, i_counting);
                    check_field("cursor_pos", want.cursor, i_cursor_pos);
                    check_field("minutes_shown", want.minutes, i_minutes_shown);
                    check_field("seconds_shown", want.seconds, i_seconds_shown);
                    check_field("finished", want.finished, i_finished);
                    check_field("key_code", want.key, i_key_code);
                end
            end
            if (i_in_valid && !i_in_stall)
                display_q.push_back(advance_timer(i_op, i_key_level));
            if (i_cfg_we && i_cfg_idx < NUM_LIMITS)
                thresholds[i_cfg_idx] = i_cfg_data;
        end
        o_mismatches <= mismatch_count;
        o_in_flight  <= display_q.size();
        o_counting   <= timer_mode;
        o_cursor     <= edit_cursor;
        o_set_min    <= set_min;
        o_set_sec    <= set_sec;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the keypad-set countdown timer. Boundary levels and every
// edit/count corner first, then random press/release sequences over several
// threshold settings, with random gaps and result stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import kbct_pkg::*;

    localparam int QUIET_LIMIT = 400;
    localparam int PHASE_ITEMS = 90;
    localparam int NUM_PHASES  = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_op     = 1'b0;
    logic [LEVEL_W-1:0]   in_level  = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_RIGHT_LIMIT;
    logic [LEVEL_W-1:0]   cfg_data  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 counting;
    logic [CURSOR_W-1:0]  cursor_pos;
    logic [MIN_W-1:0]     minutes_shown;
    logic [SEC_W-1:0]     seconds_shown;
    logic                 finished;
    logic [2:0]           key_code;

    int                   mismatches;
    int                   in_flight;
    logic                 pred_counting;
    logic [CURSOR_W-1:0]  pred_cursor;
    logic [MIN_W-1:0]     pred_min;
    logic [SEC_W-1:0]     pred_sec;

    logic [LEVEL_W-1:0]   lim [NUM_LIMITS];
    logic                 calm      = 1'b0;
    int                   sent_count = 0;
    int                   hold_left = 0;
    int                   hold_draw;
    int                   quiet     = 0;

    keypad_set_countdown_timer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (in_op),
        .i_key_level     (in_level),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_counting      (counting),
        .o_cursor_pos    (cursor_pos),
        .o_minutes_shown (minutes_shown),
        .o_seconds_shown (seconds_shown),
        .o_finished      (finished),
        .o_key_code      (key_code),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    kbct_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (in_op),
        .i_key_level     (in_level),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_counting      (counting),
        .i_cursor_pos    (cursor_pos),
        .i_minutes_shown (minutes_shown),
        .i_seconds_shown (seconds_shown),
        .i_finished      (finished),
        .i_key_code      (key_code),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_in_flight     (in_flight),
        .o_counting      (pred_counting),
        .o_cursor        (pred_cursor),
        .o_set_min       (pred_min),
        .o_set_sec       (pred_sec)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: after each accepted result stall for a random hold_draw, none while calm
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end else if (out_valid && !out_stall) begin
            hold_draw = calm ? 0 : $urandom_range(0, 4);
            hold_left <= hold_draw;
            out_stall <= (hold_draw != 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("keypad_set_countdown_timer regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic t_cfg_idx limit_reg(input int k);
        case (k)
            0:       return CFG_RIGHT_LIMIT;
            1:       return CFG_UP_LIMIT;
            2:       return CFG_DOWN_LIMIT;
            3:       return CFG_LEFT_LIMIT;
            default: return CFG_SELECT_LIMIT;
        endcase
    endfunction

    // pick a ladder level that decodes to key k under the current thresholds
    function automatic bit level_for(input t_key k, output logic [LEVEL_W-1:0] lvl);
        int lo;
        int hi;
        lo  = 0;
        lvl = '0;
        for (int j = 0; j < int'(k); j++)
            if (int'(lim[j]) > lo)
                lo = int'(lim[j]);
        hi = (k == KEY_NONE) ? 1023 : int'(lim[k]) - 1;
        if (lo > hi)
            return 1'b0;
        case ($urandom_range(0, 7))
            0:       lvl = LEVEL_W'(lo);
            1:       lvl = LEVEL_W'(hi);
            default: lvl = LEVEL_W'($urandom_range(hi, lo));
        endcase
        return 1'b1;
    endfunction

    function automatic t_key pick_dir();
        case ($urandom_range(0, 3))
            0:       return KEY_RIGHT;
            1:       return KEY_UP;
            2:       return KEY_DOWN;
            default: return KEY_LEFT;
        endcase
    endfunction

    function automatic bit can_steer();
        logic [LEVEL_W-1:0] lvl;
        return level_for(KEY_RIGHT, lvl) && level_for(KEY_LEFT, lvl) &&
               level_for(KEY_DOWN, lvl) && level_for(KEY_NONE, lvl);
    endfunction

    task automatic send_item(input logic is_tick, input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= is_tick;
        in_level <= lvl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    task automatic tap(input t_key k, input bit release_key);
        logic [LEVEL_W-1:0] lvl;
        if (!level_for(k, lvl))
            lvl = LEVEL_W'($urandom_range(0, 1023));
        send_item(1'b0, lvl);
        if (release_key) begin
            if (!level_for(KEY_NONE, lvl))
                lvl = LEVEL_W'($urandom_range(0, 1023));
            send_item(1'b0, lvl);
        end
    endtask

    // wait until every request has its result, then let the pipe settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_phase(input int phase);
        logic [LEVEL_W-1:0] v [NUM_LIMITS];
        logic [LEVEL_W-1:0] t;
        for (int k = 0; k < NUM_LIMITS; k++) begin
            case (phase)
                1:       v[k] = '0;
                2:       v[k] = '1;
                5:       v[k] = LIMIT_RESET[k];
                default: v[k] = LEVEL_W'($urandom_range(0, 1023));
            endcase
        end
        if (phase == 3) begin
            for (int a = 0; a < NUM_LIMITS - 1; a++)
                for (int b = 0; b < NUM_LIMITS - 1 - a; b++)
                    if (v[b] > v[b+1]) begin
                        t      = v[b];
                        v[b]   = v[b+1];
                        v[b+1] = t;
                    end
        end
        for (int k = 0; k < NUM_LIMITS; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= limit_reg(k);
            cfg_data <= v[k];
            lim[k]    = v[k];
            @(posedge clk);
        end
        // out-of-range index must be dropped
        if (phase == 5) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_SPARE;
            cfg_data <= LEVEL_W'($urandom_range(0, 1023));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int                  stop;
        int                  r;
        logic [CURSOR_W-1:0] target;
        stop = sent_count + n;
        while (sent_count < stop) begin
            if ($urandom_range(0, 24) == 0)
                calm <= !calm;
            r = $urandom_range(0, 99);
            if (pred_counting) begin
                if (r < 85)
                    send_item(1'b1, LEVEL_W'($urandom_range(0, 1023)));
                else
                    send_item(1'b0, LEVEL_W'($urandom_range(0, 1023)));
            end else if (pred_min != 0 && r < 60 && can_steer()) begin
                // bring the minutes back down so countdowns stay short
                target = (pred_min >= 10) ? POS_MIN_TENS : POS_MIN_UNITS;
                if (pred_cursor > target)
                    tap(KEY_LEFT, 1'b1);
                else if (pred_cursor < target)
                    tap(KEY_RIGHT, 1'b1);
                else
                    tap(KEY_DOWN, 1'b1);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 14) begin
                    if (int'(pred_min) * 60 + int'(pred_sec) <= 90)
                        tap(KEY_SELECT, 1'($urandom_range(0, 1)));
                    else
                        tap(pick_dir(), 1'b1);
                end else if (r < 20) begin
                    send_item(1'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 1023)));
                end else if (r < 26) begin
                    tap(pick_dir(), 1'b0);
                end else begin
                    tap(pick_dir(), 1'b1);
                end
            end
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_LIMITS; k++)
            lim[k] = LIMIT_RESET[k];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, default thresholds, boundary levels
        send_item(1'b0, LIMIT_RESET[CFG_LEFT_LIMIT]);         // select at 00:00
        send_item(1'b0, '0);                                  // right -> units of minutes
        send_item(1'b0, LIMIT_RESET[CFG_RIGHT_LIMIT] - 1);    // held, locked out
        send_item(1'b0, LIMIT_RESET[CFG_SELECT_LIMIT]);       // release
        tap(KEY_RIGHT, 1'b1);                                 // skips the colon
        tap(KEY_RIGHT, 1'b1);
        tap(KEY_RIGHT, 1'b1);                                 // already at the right end
        send_item(1'b0, LIMIT_RESET[CFG_UP_LIMIT]);           // down wraps to 59
        send_item(1'b0, '1);
        send_item(1'b0, LIMIT_RESET[CFG_RIGHT_LIMIT]);        // up wraps to 0
        send_item(1'b0, '1);
        send_item(1'b0, LIMIT_RESET[CFG_UP_LIMIT] - 1);       // 00:01
        send_item(1'b0, '1);
        send_item(1'b0, LIMIT_RESET[CFG_SELECT_LIMIT] - 1);   // start
        send_item(1'b0, LIMIT_RESET[CFG_DOWN_LIMIT]);         // key while counting
        send_item(1'b1, '0);                                  // reaches zero
        send_item(1'b1, '1);                                  // tick in edit mode
        send_item(1'b0, LIMIT_RESET[CFG_LEFT_LIMIT] - 1);     // left -> tens of seconds
        send_item(1'b0, '1);
        tap(KEY_LEFT, 1'b1);                                  // skips the colon
        tap(KEY_LEFT, 1'b1);
        tap(KEY_LEFT, 1'b1);                                  // already at the left end
        send_item(1'b0, LIMIT_RESET[CFG_DOWN_LIMIT] - 1);     // tens down from 0 -> 99
        send_item(1'b0, '1);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0)
                program_phase(phase);
            run_random(PHASE_ITEMS);
            settle();
        end

        if (mismatches == 0 && in_flight == 0)
            $display("keypad_set_countdown_timer regression: pass");
        else
            $display("keypad_set_countdown_timer regression: fail");
        $finish;
    end

endmodule
